>>> rtl/label_bounding_box_tracker_macros.svh
// Assertion helpers used by the tracker RTL.
`ifndef LABEL_BOUNDING_BOX_TRACKER_MACROS_SVH
`define LABEL_BOUNDING_BOX_TRACKER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define LBBT_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define LBBT_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/lbbt_pkg.sv
`default_nettype none

package lbbt_pkg;

    localparam int FIELD_W = 8;
    localparam int SIZE_W  = 9;
    localparam int CFG_IDX_W = 2;

    localparam logic [1:0] FUNC_ACCUM = 2'd0;
    localparam logic [1:0] FUNC_QUERY = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_BOX_SIZE_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_SIZE_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_SIZE_Z = 2'd2;

    localparam logic [SIZE_W-1:0] BOX_SIZE_RESET = 9'd256;

    typedef struct packed {
        logic [1:0]         func;
        logic [FIELD_W-1:0] voxel_label;
        logic [FIELD_W-1:0] pos_x;
        logic [FIELD_W-1:0] pos_y;
        logic [FIELD_W-1:0] pos_z;
    } t_in_item;

    typedef struct packed {
        logic               seen;
        logic               detached;
        logic [FIELD_W-1:0] low_x;
        logic [FIELD_W-1:0] low_y;
        logic [FIELD_W-1:0] low_z;
        logic [FIELD_W-1:0] high_x;
        logic [FIELD_W-1:0] high_y;
        logic [FIELD_W-1:0] high_z;
    } t_out_item;

endpackage

`default_nettype wire

>>> rtl/lbbt_ram.sv
`default_nettype none

module lbbt_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 256
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(DEPTH)-1:0] i_waddr,
    input  wire [WIDTH-1:0]         i_wdata,
    input  wire                     i_re,
    input  wire [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/label_bounding_box_tracker.sv
// Label bounding-box tracker.
// Input channel (i_in_valid / o_in_stall / i_in_item) carries one item per transfer:
// accumulate a voxel into its label's box, query a label, or clear all seen flags.
// Output channel (o_out_valid / i_out_stall / o_out_item) carries one result per query;
// accumulate and clear items produce no result.
// Configuration writes (i_cfg_we, i_cfg_idx, i_cfg_wdata) set the box extent per axis.
// Throughput is one item per cycle unless a query waits on a stalled output.
// The bound table sits in a one-port-read, one-port-write RAM; the read issues on the
// transfer edge, the merge and write-back happen in the following cycle, and a write
// to the label read on that same edge is forwarded from a register. A query result
// passes the merge stage register and then the output register to reach o_out_valid.
// Reset clears the seen flags, the pipeline valids and sets every box extent to 256;
// the bound table is not cleared. Reset takes effect at once, no clearing pass.
// While i_out_stall holds a pending result, a query cannot leave the merge stage and
// o_in_stall rises in the same cycle; accumulate and clear items keep flowing.
`default_nettype none

module label_bounding_box_tracker #(
    parameter int NUM_LABELS = 256,
    parameter int COORD_BITS = 8
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_in_valid,
    output logic                          o_in_stall,
    input  wire lbbt_pkg::t_in_item       i_in_item,
    output logic                          o_out_valid,
    input  wire                           i_out_stall,
    output lbbt_pkg::t_out_item           o_out_item,
    input  wire                           i_cfg_we,
    input  wire [lbbt_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire [lbbt_pkg::SIZE_W-1:0]    i_cfg_wdata
);

    import lbbt_pkg::*;

    localparam int LBL_W   = $clog2(NUM_LABELS);
    localparam int ENTRY_W = 6 * COORD_BITS;
    localparam int CMP_W   = (COORD_BITS > SIZE_W) ? COORD_BITS : SIZE_W;

    typedef logic [2:0][COORD_BITS-1:0] t_axes;

    logic [SIZE_W-1:0]      r_box_size [3];
    logic [NUM_LABELS-1:0]  r_seen;

    logic                   r_s1_valid;
    logic [1:0]             r_s1_func;
    logic                   r_s1_lbl_ok;
    logic [LBL_W-1:0]       r_s1_idx;
    t_axes                  r_s1_pos;

    logic                   r_fwd_hit;
    logic [ENTRY_W-1:0]     r_fwd_data;

    logic                   r_out_valid;
    t_out_item              r_out;

    logic                   in_accept;
    logic                   out_free;
    logic                   s1_done;
    logic                   s1_move;
    logic [LBL_W-1:0]       in_idx;
    logic                   in_lbl_ok;
    t_axes                  in_pos;

    logic [ENTRY_W-1:0]     ram_rdata;
    logic [ENTRY_W-1:0]     cur_entry;
    t_axes                  cur_lo;
    t_axes                  cur_hi;
    t_axes                  n_lo;
    t_axes                  n_hi;
    logic [ENTRY_W-1:0]     n_entry;
    logic                   cur_seen;
    logic                   ram_we;
    logic                   n_detached;
    t_out_item              n_out;

    assign in_idx    = LBL_W'(i_in_item.voxel_label);
    assign in_lbl_ok = (i_in_item.voxel_label != '0)
                       && (32'(i_in_item.voxel_label) < NUM_LABELS);
    assign in_pos[0] = COORD_BITS'(i_in_item.pos_x);
    assign in_pos[1] = COORD_BITS'(i_in_item.pos_y);
    assign in_pos[2] = COORD_BITS'(i_in_item.pos_z);

    assign out_free   = !r_out_valid || !i_out_stall;
    assign s1_done    = r_s1_valid && ((r_s1_func != FUNC_QUERY) || out_free);
    assign s1_move    = !r_s1_valid || s1_done;
    assign o_in_stall = !s1_move;
    assign in_accept  = i_in_valid && s1_move;

    lbbt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_LABELS)
    ) u_bound_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_s1_idx),
        .i_wdata (n_entry),
        .i_re    (in_accept),
        .i_raddr (in_idx),
        .o_rdata (ram_rdata)
    );

    assign cur_entry = r_fwd_hit ? r_fwd_data : ram_rdata;
    assign cur_lo    = cur_entry[3*COORD_BITS-1:0];
    assign cur_hi    = cur_entry[ENTRY_W-1:3*COORD_BITS];
    assign cur_seen  = r_s1_lbl_ok && r_seen[r_s1_idx];

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            if (!cur_seen) begin
                n_lo[a] = r_s1_pos[a];
                n_hi[a] = r_s1_pos[a];
            end else begin
                n_lo[a] = (r_s1_pos[a] < cur_lo[a]) ? r_s1_pos[a] : cur_lo[a];
                n_hi[a] = (r_s1_pos[a] > cur_hi[a]) ? r_s1_pos[a] : cur_hi[a];
            end
        end
    end

    assign n_entry = {n_hi, n_lo};
    assign ram_we  = s1_done && (r_s1_func == FUNC_ACCUM) && r_s1_lbl_ok;

    always_comb begin
        n_detached = cur_seen;
        for (int a = 0; a < 3; a++) begin
            if ((cur_lo[a] == '0)
                || (CMP_W'(cur_hi[a]) == CMP_W'(r_box_size[a] - SIZE_W'(1)))) begin
                n_detached = 1'b0;
            end
        end
    end

    always_comb begin
        n_out          = '0;
        n_out.seen     = cur_seen;
        n_out.detached = n_detached;
        if (cur_seen) begin
            n_out.low_x  = FIELD_W'(cur_lo[0]);
            n_out.low_y  = FIELD_W'(cur_lo[1]);
            n_out.low_z  = FIELD_W'(cur_lo[2]);
            n_out.high_x = FIELD_W'(cur_hi[0]);
            n_out.high_y = FIELD_W'(cur_hi[1]);
            n_out.high_z = FIELD_W'(cur_hi[2]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < 3; a++) begin
                r_box_size[a] <= BOX_SIZE_RESET;
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_BOX_SIZE_X: r_box_size[0] <= i_cfg_wdata;
                CFG_BOX_SIZE_Y: r_box_size[1] <= i_cfg_wdata;
                CFG_BOX_SIZE_Z: r_box_size[2] <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0;
        end else if (s1_done && (r_s1_func == FUNC_CLEAR)) begin
            r_seen <= '0;
        end else if (ram_we) begin
            r_seen[r_s1_idx] <= 1'b1;
        end
    end

    // advance the merge stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_fwd_hit  <= 1'b0;
        end else if (s1_move) begin
            r_s1_valid <= i_in_valid;
            r_fwd_hit  <= i_in_valid && ram_we && (in_idx == r_s1_idx);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_func   <= i_in_item.func;
            r_s1_lbl_ok <= in_lbl_ok;
            r_s1_idx    <= in_idx;
            r_s1_pos    <= in_pos;
        end
        if (ram_we) begin
            r_fwd_data <= n_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= s1_done && (r_s1_func == FUNC_QUERY);
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && s1_done && (r_s1_func == FUNC_QUERY)) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

`include "label_bounding_box_tracker_macros.svh"

    `LBBT_ASSERT_NEXT(a_query_gives_result, s1_done && (r_s1_func == FUNC_QUERY), r_out_valid, "query left merge stage without a result")
    `LBBT_ASSERT_NEXT(a_clear_drops_seen, s1_done && (r_s1_func == FUNC_CLEAR), r_seen == '0, "seen flags not cleared")
    `LBBT_ASSERT_NEXT(a_accum_sets_seen, ram_we, r_seen[$past(r_s1_idx)], "accumulated label not marked seen")
    `LBBT_ASSERT_NOW(a_fwd_needs_item, r_fwd_hit, r_s1_valid, "forward hit with empty merge stage")
    `LBBT_ASSERT_NOW(a_detached_seen, r_out_valid && r_out.detached, r_out.seen, "detached result for unseen label")

endmodule

`default_nettype wire
